@@ hdl/pitt_pkg.sv @@
// Shared widths and stage word types for the point-in-triangle test pipeline.
package pitt_pkg;

	localparam int COORD_BITS = 12;               // coordinate bits used from each field
	localparam int FIELD_W    = 12;               // width of each coordinate port
	localparam int DIFF_W     = COORD_BITS + 1;   // edge vector component
	localparam int PROD1_W    = 2 * DIFF_W;       // component product
	localparam int DOT_W      = PROD1_W + 2;      // sum of three products
	localparam int PROD2_W    = 2 * DOT_W;        // product of two dot products
	localparam int DET_W      = PROD2_W + 1;      // difference of two such products
	localparam int SUM_W      = DET_W + 1;        // nu + nv

	typedef logic [FIELD_W-1:0]        field_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD1_W-1:0] prod1_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic signed [PROD2_W-1:0] prod2_t;
	typedef logic signed [DET_W-1:0]   det_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef struct packed {
		field_t p_x, p_y, p_z;
		field_t a_x, a_y, a_z;
		field_t b_x, b_y, b_z;
		field_t c_x, c_y, c_z;
	} coords_t;

	typedef struct packed {
		diff_t e0_x, e0_y, e0_z;
		diff_t e1_x, e1_y, e1_z;
		diff_t d_x, d_y, d_z;
	} edges_t;

	typedef struct packed {
		dot_t d00, d01, d02, d11, d12;
	} dots_t;

	typedef struct packed {
		det_t den, nu, nv;
	} bary_t;

	typedef struct packed {
		logic in_tri;
		logic degen;
	} verdict_t;

endpackage

@@ hdl/pitt_edge.sv @@
// Stage 1: sign-extend the coordinates and form the edge vectors.
module pitt_edge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_in,
	input  pitt_pkg::coords_t crd,
	output logic             vld_s1,
	output pitt_pkg::edges_t edg_s1
);

	pitt_pkg::diff_t px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;

	assign px = pitt_pkg::diff_t'($signed(crd.p_x[pitt_pkg::COORD_BITS-1:0]));
	assign py = pitt_pkg::diff_t'($signed(crd.p_y[pitt_pkg::COORD_BITS-1:0]));
	assign pz = pitt_pkg::diff_t'($signed(crd.p_z[pitt_pkg::COORD_BITS-1:0]));
	assign ax = pitt_pkg::diff_t'($signed(crd.a_x[pitt_pkg::COORD_BITS-1:0]));
	assign ay = pitt_pkg::diff_t'($signed(crd.a_y[pitt_pkg::COORD_BITS-1:0]));
	assign az = pitt_pkg::diff_t'($signed(crd.a_z[pitt_pkg::COORD_BITS-1:0]));
	assign bx = pitt_pkg::diff_t'($signed(crd.b_x[pitt_pkg::COORD_BITS-1:0]));
	assign by = pitt_pkg::diff_t'($signed(crd.b_y[pitt_pkg::COORD_BITS-1:0]));
	assign bz = pitt_pkg::diff_t'($signed(crd.b_z[pitt_pkg::COORD_BITS-1:0]));
	assign cx = pitt_pkg::diff_t'($signed(crd.c_x[pitt_pkg::COORD_BITS-1:0]));
	assign cy = pitt_pkg::diff_t'($signed(crd.c_y[pitt_pkg::COORD_BITS-1:0]));
	assign cz = pitt_pkg::diff_t'($signed(crd.c_z[pitt_pkg::COORD_BITS-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	// Hold payload without reset; the valid bit qualifies it.
	always_ff @(posedge clk) begin
		edg_s1.e0_x <= cx - ax;
		edg_s1.e0_y <= cy - ay;
		edg_s1.e0_z <= cz - az;
		edg_s1.e1_x <= bx - ax;
		edg_s1.e1_y <= by - ay;
		edg_s1.e1_z <= bz - az;
		edg_s1.d_x  <= px - ax;
		edg_s1.d_y  <= py - ay;
		edg_s1.d_z  <= pz - az;
	end

endmodule

@@ hdl/pitt_dot.sv @@
// Stages 2 and 3: component products, then the five dot products.
module pitt_dot (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s1,
	input  pitt_pkg::edges_t edg_s1,
	output logic             vld_s3,
	output pitt_pkg::dots_t  dot_s3
);

	logic            vld_s2;
	pitt_pkg::prod1_t prd_s2 [15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		// e0.e0
		prd_s2[0]  <= edg_s1.e0_x * edg_s1.e0_x;
		prd_s2[1]  <= edg_s1.e0_y * edg_s1.e0_y;
		prd_s2[2]  <= edg_s1.e0_z * edg_s1.e0_z;
		// e0.e1
		prd_s2[3]  <= edg_s1.e0_x * edg_s1.e1_x;
		prd_s2[4]  <= edg_s1.e0_y * edg_s1.e1_y;
		prd_s2[5]  <= edg_s1.e0_z * edg_s1.e1_z;
		// e0.d
		prd_s2[6]  <= edg_s1.e0_x * edg_s1.d_x;
		prd_s2[7]  <= edg_s1.e0_y * edg_s1.d_y;
		prd_s2[8]  <= edg_s1.e0_z * edg_s1.d_z;
		// e1.e1
		prd_s2[9]  <= edg_s1.e1_x * edg_s1.e1_x;
		prd_s2[10] <= edg_s1.e1_y * edg_s1.e1_y;
		prd_s2[11] <= edg_s1.e1_z * edg_s1.e1_z;
		// e1.d
		prd_s2[12] <= edg_s1.e1_x * edg_s1.d_x;
		prd_s2[13] <= edg_s1.e1_y * edg_s1.d_y;
		prd_s2[14] <= edg_s1.e1_z * edg_s1.d_z;
	end

	always_ff @(posedge clk) begin
		dot_s3.d00 <= pitt_pkg::dot_t'(prd_s2[0]) + pitt_pkg::dot_t'(prd_s2[1])
			+ pitt_pkg::dot_t'(prd_s2[2]);
		dot_s3.d01 <= pitt_pkg::dot_t'(prd_s2[3]) + pitt_pkg::dot_t'(prd_s2[4])
			+ pitt_pkg::dot_t'(prd_s2[5]);
		dot_s3.d02 <= pitt_pkg::dot_t'(prd_s2[6]) + pitt_pkg::dot_t'(prd_s2[7])
			+ pitt_pkg::dot_t'(prd_s2[8]);
		dot_s3.d11 <= pitt_pkg::dot_t'(prd_s2[9]) + pitt_pkg::dot_t'(prd_s2[10])
			+ pitt_pkg::dot_t'(prd_s2[11]);
		dot_s3.d12 <= pitt_pkg::dot_t'(prd_s2[12]) + pitt_pkg::dot_t'(prd_s2[13])
			+ pitt_pkg::dot_t'(prd_s2[14]);
	end

endmodule

@@ hdl/pitt_cross.sv @@
// Stages 4 and 5: products of dot products, then determinant and numerators.
module pitt_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_s3,
	input  pitt_pkg::dots_t dot_s3,
	output logic            vld_s5,
	output pitt_pkg::bary_t bar_s5
);

	logic             vld_s4;
	pitt_pkg::prod2_t m0011_s4, m0101_s4, m1102_s4, m0112_s4, m0012_s4, m0102_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		m0011_s4 <= dot_s3.d00 * dot_s3.d11;
		m0101_s4 <= dot_s3.d01 * dot_s3.d01;
		m1102_s4 <= dot_s3.d11 * dot_s3.d02;
		m0112_s4 <= dot_s3.d01 * dot_s3.d12;
		m0012_s4 <= dot_s3.d00 * dot_s3.d12;
		m0102_s4 <= dot_s3.d01 * dot_s3.d02;
	end

	always_ff @(posedge clk) begin
		bar_s5.den <= pitt_pkg::det_t'(m0011_s4) - pitt_pkg::det_t'(m0101_s4);
		bar_s5.nu  <= pitt_pkg::det_t'(m1102_s4) - pitt_pkg::det_t'(m0112_s4);
		bar_s5.nv  <= pitt_pkg::det_t'(m0012_s4) - pitt_pkg::det_t'(m0102_s4);
	end

endmodule

@@ hdl/pitt_decide.sv @@
// Stage 6: sign and range tests that give the inside and degenerate flags.
module pitt_decide (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s5,
	input  pitt_pkg::bary_t    bar_s5,
	output logic               vld_s6,
	output pitt_pkg::verdict_t vrd_s6
);

	logic           den_le0, nu_ge0, nv_ge0, sum_ok;
	pitt_pkg::sum_t nsum;

	assign nsum    = pitt_pkg::sum_t'(bar_s5.nu) + pitt_pkg::sum_t'(bar_s5.nv);
	assign den_le0 = bar_s5.den[pitt_pkg::DET_W-1] || (bar_s5.den == '0);
	assign nu_ge0  = !bar_s5.nu[pitt_pkg::DET_W-1];
	assign nv_ge0  = !bar_s5.nv[pitt_pkg::DET_W-1];
	assign sum_ok  = nsum <= pitt_pkg::sum_t'(bar_s5.den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		vrd_s6.degen  <= den_le0;
		vrd_s6.in_tri <= !den_le0 && nu_ge0 && nv_ge0 && sum_ok;
	end

endmodule

@@ hdl/point_in_triangle_test.sv @@
// Top level of the barycentric point-in-triangle test pipeline.
//
// Takes one word (point P and corners A, B, C) on every clock where start is
// high; busy never rises, so a word may be offered in every cycle. Each word
// gives exactly one result, flagged by done, once it has passed every register
// stage. inside_res is 1 when P projected onto the triangle's plane lies
// inside or on the triangle, degenerate is 1 when the triangle has zero area
// (inside_res is then 0). The receiver cannot stall the result; it must take
// the word in the cycle done is high. The six register stages are: edge
// vectors, component products, dot products, wide products, determinant and
// numerators, final compare. Only the low COORD_BITS bits of each coordinate
// are used, sign-extended. No division: the tests compare the barycentric
// numerators against the determinant exactly.
module point_in_triangle_test (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pitt_pkg::field_t     p_x,
	input  pitt_pkg::field_t     p_y,
	input  pitt_pkg::field_t     p_z,
	input  pitt_pkg::field_t     a_x,
	input  pitt_pkg::field_t     a_y,
	input  pitt_pkg::field_t     a_z,
	input  pitt_pkg::field_t     b_x,
	input  pitt_pkg::field_t     b_y,
	input  pitt_pkg::field_t     b_z,
	input  pitt_pkg::field_t     c_x,
	input  pitt_pkg::field_t     c_y,
	input  pitt_pkg::field_t     c_z,
	output logic                 done,
	output logic                 inside_res,
	output logic                 degenerate
);

	pitt_pkg::coords_t  crd;
	pitt_pkg::edges_t   edg_s1;
	pitt_pkg::dots_t    dot_s3;
	pitt_pkg::bary_t    bar_s5;
	pitt_pkg::verdict_t vrd_s6;
	logic               vld_s1, vld_s3, vld_s5, vld_s6;

	// The pipeline advances every cycle, so never hold off the sender.
	assign busy = 1'b0;

	// Gather the coordinate ports into one word for the first stage.
	assign crd.p_x = p_x;
	assign crd.p_y = p_y;
	assign crd.p_z = p_z;
	assign crd.a_x = a_x;
	assign crd.a_y = a_y;
	assign crd.a_z = a_z;
	assign crd.b_x = b_x;
	assign crd.b_y = b_y;
	assign crd.b_z = b_z;
	assign crd.c_x = c_x;
	assign crd.c_y = c_y;
	assign crd.c_z = c_z;

	// Edge vectors e0 = C - A, e1 = B - A, d = P - A.
	pitt_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (start),
		.crd    (crd),
		.vld_s1 (vld_s1),
		.edg_s1 (edg_s1)
	);

	// Five dot products over two stages: multiply, then add three.
	pitt_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.edg_s1 (edg_s1),
		.vld_s3 (vld_s3),
		.dot_s3 (dot_s3)
	);

	// Determinant and barycentric numerators over two stages.
	pitt_cross u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s3 (vld_s3),
		.dot_s3 (dot_s3),
		.vld_s5 (vld_s5),
		.bar_s5 (bar_s5)
	);

	// Final compare; its registers drive the result ports directly.
	pitt_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s5 (vld_s5),
		.bar_s5 (bar_s5),
		.vld_s6 (vld_s6),
		.vrd_s6 (vrd_s6)
	);

	assign done       = vld_s6;
	assign inside_res = vrd_s6.in_tri;
	assign degenerate = vrd_s6.degen;

endmodule
